@@ src/sict_pkg.sv @@
// Shared types and register map for the segment interior crossing test.
package sict_pkg;

    localparam int AREA_EPS_WIDTH = 16;
    localparam int TOL_WIDTH      = 20;
    localparam int ADDR_WIDTH     = 4;
    localparam int DATA_WIDTH     = 32;

    localparam logic [1:0] REG_AREA_EPSILON       = 2'd0;
    localparam logic [1:0] REG_ENDPOINT_TOLERANCE = 2'd1;
    localparam logic [1:0] REG_FRACTION_EPSILON   = 2'd2;

    localparam logic [AREA_EPS_WIDTH-1:0] AREA_EPSILON_RESET       = 16'd4;
    localparam logic [TOL_WIDTH-1:0]      ENDPOINT_TOLERANCE_RESET = 20'd1074;
    localparam logic [TOL_WIDTH-1:0]      FRACTION_EPSILON_RESET   = 20'd1;

    typedef struct packed {
        logic [AREA_EPS_WIDTH-1:0] area_epsilon;
        logic [TOL_WIDTH-1:0]      endpoint_tolerance;
        logic [TOL_WIDTH-1:0]      fraction_epsilon;
    } cfg_t;

endpackage

@@ src/sict_diff.sv @@
// Coordinate capture and difference vectors.
module sict_diff #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [31:0]                   span_start_x,
    input  logic [31:0]                   span_start_y,
    input  logic [31:0]                   span_end_x,
    input  logic [31:0]                   span_end_y,
    input  logic [31:0]                   obstacle_start_x,
    input  logic [31:0]                   obstacle_start_y,
    input  logic [31:0]                   obstacle_end_x,
    input  logic [31:0]                   obstacle_end_y,
    output logic                          out_valid,
    output logic signed [COORD_WIDTH:0]   dx,
    output logic signed [COORD_WIDTH:0]   dy,
    output logic signed [COORD_WIDTH:0]   ex,
    output logic signed [COORD_WIDTH:0]   ey,
    output logic signed [COORD_WIDTH:0]   px,
    output logic signed [COORD_WIDTH:0]   py,
    output logic signed [COORD_WIDTH:0]   qx,
    output logic signed [COORD_WIDTH:0]   qy
);

    localparam int DW = COORD_WIDTH + 1;

    logic                          v0_reg;
    logic signed [COORD_WIDTH-1:0] s0x_reg, s0y_reg, s1x_reg, s1y_reg;
    logic signed [COORD_WIDTH-1:0] b0x_reg, b0y_reg, b1x_reg, b1y_reg;
    logic                          v1_reg;
    logic signed [DW-1:0]          dx_reg, dy_reg, ex_reg, ey_reg;
    logic signed [DW-1:0]          px_reg, py_reg, qx_reg, qy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s0x_reg <= signed'(span_start_x[COORD_WIDTH-1:0]);
        s0y_reg <= signed'(span_start_y[COORD_WIDTH-1:0]);
        s1x_reg <= signed'(span_end_x[COORD_WIDTH-1:0]);
        s1y_reg <= signed'(span_end_y[COORD_WIDTH-1:0]);
        b0x_reg <= signed'(obstacle_start_x[COORD_WIDTH-1:0]);
        b0y_reg <= signed'(obstacle_start_y[COORD_WIDTH-1:0]);
        b1x_reg <= signed'(obstacle_end_x[COORD_WIDTH-1:0]);
        b1y_reg <= signed'(obstacle_end_y[COORD_WIDTH-1:0]);
        dx_reg  <= DW'(s1x_reg) - DW'(s0x_reg);
        dy_reg  <= DW'(s1y_reg) - DW'(s0y_reg);
        ex_reg  <= DW'(b1x_reg) - DW'(b0x_reg);
        ey_reg  <= DW'(b1y_reg) - DW'(b0y_reg);
        px_reg  <= DW'(b0x_reg) - DW'(s0x_reg);
        py_reg  <= DW'(b0y_reg) - DW'(s0y_reg);
        qx_reg  <= DW'(b1x_reg) - DW'(s0x_reg);
        qy_reg  <= DW'(b1y_reg) - DW'(s0y_reg);
    end

    assign out_valid = v1_reg;
    assign dx = dx_reg;
    assign dy = dy_reg;
    assign ex = ex_reg;
    assign ey = ey_reg;
    assign px = px_reg;
    assign py = py_reg;
    assign qx = qx_reg;
    assign qy = qy_reg;

endmodule

@@ src/sict_area.sv @@
// Cross and dot products of the difference vectors.
module sict_area #(
    parameter int COORD_WIDTH = 32,
    parameter int AW          = 2 * (COORD_WIDTH + 1) + 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [COORD_WIDTH:0]   dx,
    input  logic signed [COORD_WIDTH:0]   dy,
    input  logic signed [COORD_WIDTH:0]   ex,
    input  logic signed [COORD_WIDTH:0]   ey,
    input  logic signed [COORD_WIDTH:0]   px,
    input  logic signed [COORD_WIDTH:0]   py,
    input  logic signed [COORD_WIDTH:0]   qx,
    input  logic signed [COORD_WIDTH:0]   qy,
    output logic                          out_valid,
    output logic signed [AW-1:0]          len2,
    output logic signed [AW-1:0]          den,
    output logic signed [AW-1:0]          cross_pd,
    output logic signed [AW-1:0]          cross_qd,
    output logic signed [AW-1:0]          dot_p,
    output logic signed [AW-1:0]          dot_q,
    output logic signed [AW-1:0]          cross_pe
);

    localparam int PW = 2 * (COORD_WIDTH + 1);

    logic              v2_reg, v3_reg;
    logic signed [PW-1:0] dxdx_reg, dydy_reg, dxey_reg, dyex_reg;
    logic signed [PW-1:0] pxdy_reg, pydx_reg, qxdy_reg, qydx_reg;
    logic signed [PW-1:0] pxdx_reg, pydy_reg, qxdx_reg, qydy_reg;
    logic signed [PW-1:0] pxey_reg, pyex_reg;
    logic signed [AW-1:0] len2_reg, den_reg, cpd_reg, cqd_reg;
    logic signed [AW-1:0] dp_reg, dq_reg, cpe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= in_valid;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dxdx_reg <= PW'(dx) * PW'(dx);
        dydy_reg <= PW'(dy) * PW'(dy);
        dxey_reg <= PW'(dx) * PW'(ey);
        dyex_reg <= PW'(dy) * PW'(ex);
        pxdy_reg <= PW'(px) * PW'(dy);
        pydx_reg <= PW'(py) * PW'(dx);
        qxdy_reg <= PW'(qx) * PW'(dy);
        qydx_reg <= PW'(qy) * PW'(dx);
        pxdx_reg <= PW'(px) * PW'(dx);
        pydy_reg <= PW'(py) * PW'(dy);
        qxdx_reg <= PW'(qx) * PW'(dx);
        qydy_reg <= PW'(qy) * PW'(dy);
        pxey_reg <= PW'(px) * PW'(ey);
        pyex_reg <= PW'(py) * PW'(ex);
        len2_reg <= AW'(dxdx_reg) + AW'(dydy_reg);
        den_reg  <= AW'(dxey_reg) - AW'(dyex_reg);
        cpd_reg  <= AW'(pxdy_reg) - AW'(pydx_reg);
        cqd_reg  <= AW'(qxdy_reg) - AW'(qydx_reg);
        dp_reg   <= AW'(pxdx_reg) + AW'(pydy_reg);
        dq_reg   <= AW'(qxdx_reg) + AW'(qydy_reg);
        cpe_reg  <= AW'(pxey_reg) - AW'(pyex_reg);
    end

    assign out_valid = v3_reg;
    assign len2      = len2_reg;
    assign den       = den_reg;
    assign cross_pd  = cpd_reg;
    assign cross_qd  = cqd_reg;
    assign dot_p     = dp_reg;
    assign dot_q     = dq_reg;
    assign cross_pe  = cpe_reg;

endmodule

@@ src/sict_decide.sv @@
// Parallel classification, tolerance scaling and final fraction compares.
module sict_decide #(
    parameter int AW            = 67,
    parameter int FRACTION_BITS = 30
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sict_pkg::cfg_t         cfg,
    input  logic                   in_valid,
    input  logic signed [AW-1:0]   len2,
    input  logic signed [AW-1:0]   den,
    input  logic signed [AW-1:0]   cross_pd,
    input  logic signed [AW-1:0]   cross_qd,
    input  logic signed [AW-1:0]   dot_p,
    input  logic signed [AW-1:0]   dot_q,
    input  logic signed [AW-1:0]   cross_pe,
    output logic                   done,
    output logic                   crosses_interior
);

    localparam int CW = AW + FRACTION_BITS + sict_pkg::TOL_WIDTH + 2;

    logic signed [AW-1:0] ae;
    logic signed [AW-1:0] den_a, ns_a, nb_a, cpd_a, cqd_a;
    logic signed [AW-1:0] lo0, hi0, lo_c, hi_c;
    logic                 den_neg;

    logic                 v4_reg, deg_reg, par_reg, col_reg;
    logic signed [AW-1:0] len2_reg, lo_reg, hi_reg, dena_reg, ns_reg, nb_reg;

    logic                 v5_reg, deg5_reg, par5_reg, col5_reg;
    logic signed [CW-1:0] l5_reg, lo5_reg, hi5_reg, d5_reg, ns5_reg, nb5_reg;
    logic signed [CW-1:0] tol5_reg, fe5_reg;
    logic signed [AW-1:0] base;
    logic signed [CW-1:0] base_x, t_x, f_x;

    logic signed [CW-1:0] full_l, full_d, nsf, nbf;
    logic                 par_ok, gen_ok, result;
    logic                 done_reg, crosses_reg;

    always_comb
    begin
        ae      = $signed({{(AW - sict_pkg::AREA_EPS_WIDTH){1'b0}}, cfg.area_epsilon});
        den_neg = den[AW-1];
        den_a   = den_neg ? -den : den;
        ns_a    = den_neg ? -cross_pe : cross_pe;
        nb_a    = den_neg ? -cross_pd : cross_pd;
        cpd_a   = cross_pd[AW-1] ? -cross_pd : cross_pd;
        cqd_a   = cross_qd[AW-1] ? -cross_qd : cross_qd;
        lo0     = (dot_p <= dot_q) ? dot_p : dot_q;
        hi0     = (dot_p <= dot_q) ? dot_q : dot_p;
        lo_c    = lo0[AW-1] ? '0 : lo0;
        hi_c    = (hi0 > len2) ? len2 : hi0;
    end

    always_comb
    begin
        base   = par_reg ? len2_reg : dena_reg;
        base_x = CW'(base);
        t_x    = $signed({{(CW - sict_pkg::TOL_WIDTH){1'b0}}, cfg.endpoint_tolerance});
        f_x    = $signed({{(CW - sict_pkg::TOL_WIDTH){1'b0}}, cfg.fraction_epsilon});
    end

    always_comb
    begin
        full_l = l5_reg <<< FRACTION_BITS;
        full_d = d5_reg <<< FRACTION_BITS;
        nsf    = ns5_reg <<< FRACTION_BITS;
        nbf    = nb5_reg <<< FRACTION_BITS;
        par_ok = col5_reg
              && (((hi5_reg - lo5_reg) <<< FRACTION_BITS) > tol5_reg)
              && ((hi5_reg <<< FRACTION_BITS) > tol5_reg)
              && (((lo5_reg <<< FRACTION_BITS) + tol5_reg) < full_l);
        gen_ok = (nsf > tol5_reg)
              && ((nsf + tol5_reg) < full_d)
              && ((nbf + fe5_reg) >= 0)
              && (nbf <= (full_d + fe5_reg));
        result = !deg5_reg && (par5_reg ? par_ok : gen_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v4_reg   <= in_valid;
            v5_reg   <= v4_reg;
            done_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        deg_reg     <= (len2 <= ae);
        par_reg     <= (den_a <= ae);
        col_reg     <= (cpd_a <= ae) && (cqd_a <= ae);
        len2_reg    <= len2;
        lo_reg      <= lo_c;
        hi_reg      <= hi_c;
        dena_reg    <= den_a;
        ns_reg      <= ns_a;
        nb_reg      <= nb_a;
        deg5_reg    <= deg_reg;
        par5_reg    <= par_reg;
        col5_reg    <= col_reg;
        l5_reg      <= CW'(len2_reg);
        lo5_reg     <= CW'(lo_reg);
        hi5_reg     <= CW'(hi_reg);
        d5_reg      <= CW'(dena_reg);
        ns5_reg     <= CW'(ns_reg);
        nb5_reg     <= CW'(nb_reg);
        tol5_reg    <= base_x * t_x;
        fe5_reg     <= base_x * f_x;
        crosses_reg <= result;
    end

    assign done             = done_reg;
    assign crosses_interior = crosses_reg;

endmodule

@@ src/segment_interior_crossing_test_core.sv @@
// Top level of the segment interior crossing test with its register port.
// Throughput: one transaction per cycle; busy stays low, the pipeline never stalls.
// Depth is set by the register stages: capture, differences, products,
// area sums, classification, tolerance products, then the result register.
// Reset clears the valid pipeline and loads the register reset values.
module segment_interior_crossing_test_core #(
    parameter int COORD_WIDTH   = 32,
    parameter int FRACTION_BITS = 30
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sict_pkg::ADDR_WIDTH-1:0]   paddr,
    input  logic [sict_pkg::DATA_WIDTH-1:0]   pwdata,
    output logic [sict_pkg::DATA_WIDTH-1:0]   prdata,
    output logic                              pready,
    input  logic                              start,
    output logic                              busy,
    output logic                              done,
    input  logic [31:0]                       span_start_x,
    input  logic [31:0]                       span_start_y,
    input  logic [31:0]                       span_end_x,
    input  logic [31:0]                       span_end_y,
    input  logic [31:0]                       obstacle_start_x,
    input  logic [31:0]                       obstacle_start_y,
    input  logic [31:0]                       obstacle_end_x,
    input  logic [31:0]                       obstacle_end_y,
    output logic                              crosses_interior
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int AW = 2 * DW + 1;

    sict_pkg::cfg_t cfg_reg;
    logic [1:0]     reg_index;
    logic           wr_en;

    logic                 v1;
    logic signed [DW-1:0] dx, dy, ex, ey, px, py, qx, qy;
    logic                 v3;
    logic signed [AW-1:0] len2, den, cross_pd, cross_qd, dot_p, dot_q, cross_pe;

    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.area_epsilon       <= sict_pkg::AREA_EPSILON_RESET;
            cfg_reg.endpoint_tolerance <= sict_pkg::ENDPOINT_TOLERANCE_RESET;
            cfg_reg.fraction_epsilon   <= sict_pkg::FRACTION_EPSILON_RESET;
        end
        else if (wr_en)
        begin
            case (reg_index)
                sict_pkg::REG_AREA_EPSILON:
                    cfg_reg.area_epsilon <= pwdata[sict_pkg::AREA_EPS_WIDTH-1:0];
                sict_pkg::REG_ENDPOINT_TOLERANCE:
                    cfg_reg.endpoint_tolerance <= pwdata[sict_pkg::TOL_WIDTH-1:0];
                sict_pkg::REG_FRACTION_EPSILON:
                    cfg_reg.fraction_epsilon <= pwdata[sict_pkg::TOL_WIDTH-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            sict_pkg::REG_AREA_EPSILON:
                prdata = sict_pkg::DATA_WIDTH'(cfg_reg.area_epsilon);
            sict_pkg::REG_ENDPOINT_TOLERANCE:
                prdata = sict_pkg::DATA_WIDTH'(cfg_reg.endpoint_tolerance);
            sict_pkg::REG_FRACTION_EPSILON:
                prdata = sict_pkg::DATA_WIDTH'(cfg_reg.fraction_epsilon);
            default:
                prdata = '0;
        endcase
    end

    sict_diff #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_diff (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (start && !busy),
        .span_start_x     (span_start_x),
        .span_start_y     (span_start_y),
        .span_end_x       (span_end_x),
        .span_end_y       (span_end_y),
        .obstacle_start_x (obstacle_start_x),
        .obstacle_start_y (obstacle_start_y),
        .obstacle_end_x   (obstacle_end_x),
        .obstacle_end_y   (obstacle_end_y),
        .out_valid        (v1),
        .dx               (dx),
        .dy               (dy),
        .ex               (ex),
        .ey               (ey),
        .px               (px),
        .py               (py),
        .qx               (qx),
        .qy               (qy)
    );

    sict_area #(
        .COORD_WIDTH(COORD_WIDTH),
        .AW         (AW)
    ) u_area (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1),
        .dx        (dx),
        .dy        (dy),
        .ex        (ex),
        .ey        (ey),
        .px        (px),
        .py        (py),
        .qx        (qx),
        .qy        (qy),
        .out_valid (v3),
        .len2      (len2),
        .den       (den),
        .cross_pd  (cross_pd),
        .cross_qd  (cross_qd),
        .dot_p     (dot_p),
        .dot_q     (dot_q),
        .cross_pe  (cross_pe)
    );

    sict_decide #(
        .AW           (AW),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_decide (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .in_valid         (v3),
        .len2             (len2),
        .den              (den),
        .cross_pd         (cross_pd),
        .cross_qd         (cross_qd),
        .dot_p            (dot_p),
        .dot_q            (dot_q),
        .cross_pe         (cross_pe),
        .done             (done),
        .crosses_interior (crosses_interior)
    );

endmodule

@@ src/sict_checker.sv @@
// Port-level checks for the segment interior crossing test, bound to the top level.
module sict_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic pready
);

    localparam int LATENCY = 7;

    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("done without a start transaction");

    a_start_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("start transaction lost");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind segment_interior_crossing_test_core sict_checker u_sict_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .pready (pready)
);
